[hdl/fnns_pkg.sv]
// Shared constants, types and state codes of the four-nearest-neighbor search unit.
`default_nettype none

package fnns_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 16;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int IDX_W      = 10;
   localparam int CNT_W      = 11;
   localparam int SQ_W       = 2 * COORD_BITS + 1;
   localparam int DIST_W     = 17;
   localparam int ROOT_W     = (SQ_W + 1) / 2;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 1;
   localparam int STEP_W     = $clog2(ROOT_W + 1);
   localparam int NUM_RANKS  = 4;
   localparam int RANK_W     = $clog2(NUM_RANKS);
   localparam int FOUND_W    = 3;

   localparam logic [DIST_W-1:0] DIST_EMPTY = {DIST_W{1'b1}};

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef struct packed {
      logic             v;
      logic [SQ_W-1:0]  d;
      logic [IDX_W-1:0] i;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_QLOAD,
      S_SCAN,
      S_DRAIN,
      S_SQ_START,
      S_SQ_WAIT,
      S_OUT
   } state_type;

endpackage

`default_nettype wire

[hdl/fnns_cell.sv]
// One cell of the sorted candidate row: keeps the best entry seen and passes the other on.
`default_nettype none

module fnns_cell
   import fnns_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      clear,
   input  wire entry_type in_entry,
   output entry_type      held,
   output entry_type      pass
);

   entry_type held_ff, held_in;
   entry_type pass_ff, pass_in;
   logic      ahead;

   // Equal distances are ordered by slot index, so the lower slot always ranks first.
   assign ahead = (in_entry.d < held_ff.d)
                  || ((in_entry.d == held_ff.d) && (in_entry.i < held_ff.i));

   always_comb begin
      held_in = held_ff;
      pass_in = '0;
      if (clear) begin
         held_in = '0;
      end else if (in_entry.v) begin
         if (!held_ff.v) begin
            held_in = in_entry;
         end else if (ahead) begin
            held_in = in_entry;
            pass_in = held_ff;
         end else begin
            pass_in = in_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         pass_ff <= '0;
      end else begin
         held_ff <= held_in;
         pass_ff <= pass_in;
      end
   end

   assign held = held_ff;
   assign pass = pass_ff;

endmodule

`default_nettype wire

[hdl/fnns_sqrt.sv]
// Digit-by-digit floor square root that produces one result bit per cycle.
`default_nettype none

module fnns_sqrt
   import fnns_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SQ_W-1:0]   radicand,
   output logic                   done,
   output logic [ROOT_W-1:0]      root
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W+1:0]  cur;
   logic [REM_W+2:0]  trial;

   assign cur   = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial = {1'b0, cur} - (REM_W + 3)'({root_ff, 2'b01});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(ROOT_W);
         rad_in  = RAD_W'(radicand);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         step_in = step_ff - 1'b1;
         if (!trial[REM_W+2]) begin
            rem_in  = trial[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

[hdl/four_nearest_neighbor_search_unit.sv]
// Top level of the four-nearest-neighbor search unit: point store, scan pipe and sequencer.
//
// Requests arrive on the req_ channel with valid and ready. A request with
// opcode write stores a point and gives no response. A query request reads
// the query point, then streams slots 0 to scan_count minus one out of the
// point memory, one per cycle, through a four-stage distance pipe into a row
// of four sorting cells. After the row drains, a shared bit-serial square
// root converts the four kept distances, one result bit per cycle. The
// scan_count of a query is clamped to the store size. Queries are worked
// one at a time.
// The response sits in an output register on the rsp_ channel. While it
// waits, writes and a next query are still taken; a finished query whose
// response cannot yet be loaded holds until the receiver takes the old one.
// Synchronous reset clears the sequencer, pipe and cells; the point store
// keeps whatever it holds and is undefined until written.
`default_nettype none

module four_nearest_neighbor_search_unit
   import fnns_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_opcode,
   input  wire logic [IDX_W-1:0]      req_point_index,
   input  wire logic [COORD_BITS-1:0] req_x_coord,
   input  wire logic [COORD_BITS-1:0] req_y_coord,
   input  wire logic [CNT_W-1:0]      req_scan_count,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [DIST_W-1:0]          rsp_dist_first,
   output logic [DIST_W-1:0]          rsp_dist_second,
   output logic [DIST_W-1:0]          rsp_dist_third,
   output logic [DIST_W-1:0]          rsp_dist_fourth,
   output logic [IDX_W-1:0]           rsp_index_first,
   output logic [IDX_W-1:0]           rsp_index_second,
   output logic [IDX_W-1:0]           rsp_index_third,
   output logic [IDX_W-1:0]           rsp_index_fourth,
   output logic [FOUND_W-1:0]         rsp_found_count
);

   state_type state_ff, state_in;

   logic [COORD_BITS-1:0] x_store_ff [MAX_POINTS];
   logic [COORD_BITS-1:0] y_store_ff [MAX_POINTS];

   logic                  accept;
   logic                  wr_en;
   logic                  issue;
   logic                  clear_cells;
   logic                  sqrt_start;
   logic                  load_out;
   logic                  in_flight;
   logic [ADDR_W-1:0]     rd_addr;

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      j_ff, j_in;
   logic [IDX_W-1:0]      q_idx_ff, q_idx_in;
   logic [COORD_BITS-1:0] qx_ff, qx_in;
   logic [COORD_BITS-1:0] qy_ff, qy_in;
   logic [RANK_W-1:0]     rank_ff, rank_in;

   logic [COORD_BITS-1:0] rd_x_ff, rd_y_ff;
   logic                  s1_v_ff, s2_v_ff, s3_v_ff;
   logic [IDX_W-1:0]      s1_j_ff, s2_j_ff, s3_j_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff;
   logic [2*COORD_BITS-1:0] sqx_ff, sqy_ff;
   entry_type             cand_ff;

   entry_type             link [NUM_RANKS+1];
   entry_type             cell_held [NUM_RANKS];

   logic                  sqrt_done;
   logic [ROOT_W-1:0]     sqrt_root;
   logic [DIST_W-1:0]     root_ff [NUM_RANKS];
   logic [FOUND_W-1:0]    found;

   logic                  rsp_valid_ff;
   logic [DIST_W-1:0]     rsp_dist_ff [NUM_RANKS];
   logic [IDX_W-1:0]      rsp_index_ff [NUM_RANKS];
   logic [FOUND_W-1:0]    rsp_found_ff;

   assign accept = req_valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_opcode == OP_QUERY)) begin
               state_in = S_QLOAD;
            end
         end
         S_QLOAD: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (j_ff >= cnt_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!in_flight) begin
               state_in = S_SQ_START;
            end
         end
         S_SQ_START: begin
            state_in = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (sqrt_done) begin
               if (rank_ff == RANK_W'(NUM_RANKS - 1)) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_SQ_START;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready   = 1'b0;
      issue       = 1'b0;
      clear_cells = 1'b0;
      sqrt_start  = 1'b0;
      load_out    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_QLOAD: begin
            clear_cells = 1'b1;
         end
         S_SCAN: begin
            issue = (j_ff < cnt_ff);
         end
         S_DRAIN: begin
         end
         S_SQ_START: begin
            sqrt_start = 1'b1;
         end
         S_SQ_WAIT: begin
         end
         S_OUT: begin
            load_out = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   assign wr_en   = accept && (req_opcode == OP_WRITE)
                    && (32'(req_point_index) < MAX_POINTS);
   assign rd_addr = (state_ff == S_IDLE) ? req_point_index[ADDR_W-1:0] : j_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_store_ff[req_point_index[ADDR_W-1:0]] <= req_x_coord;
         y_store_ff[req_point_index[ADDR_W-1:0]] <= req_y_coord;
      end
      rd_x_ff <= x_store_ff[rd_addr];
      rd_y_ff <= y_store_ff[rd_addr];
   end

   always_comb begin
      cnt_in   = cnt_ff;
      j_in     = j_ff;
      q_idx_in = q_idx_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      rank_in  = rank_ff;
      if (accept && (req_opcode == OP_QUERY)) begin
         q_idx_in = req_point_index;
         j_in     = '0;
         rank_in  = '0;
         if (32'(req_scan_count) > MAX_POINTS) begin
            cnt_in = CNT_W'(MAX_POINTS);
         end else begin
            cnt_in = req_scan_count;
         end
      end
      if (state_ff == S_QLOAD) begin
         qx_in = rd_x_ff;
         qy_in = rd_y_ff;
      end
      if (issue) begin
         j_in = j_ff + 1'b1;
      end
      if ((state_ff == S_SQ_WAIT) && sqrt_done) begin
         rank_in = rank_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         j_ff     <= '0;
         cnt_ff   <= '0;
         rank_ff  <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         cnt_ff   <= cnt_in;
         rank_ff  <= rank_in;
      end
      q_idx_ff <= q_idx_in;
      qx_ff    <= qx_in;
      qy_ff    <= qy_in;
   end

   // Distance pipe: read, absolute difference, squares, sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         cand_ff <= '0;
      end else begin
         s1_v_ff   <= issue;
         s2_v_ff   <= s1_v_ff && (s1_j_ff != q_idx_ff);
         s3_v_ff   <= s2_v_ff;
         cand_ff.v <= s3_v_ff;
         cand_ff.d <= SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
         cand_ff.i <= s3_j_ff;
      end
      s1_j_ff <= j_ff[IDX_W-1:0];
      s2_j_ff <= s1_j_ff;
      s3_j_ff <= s2_j_ff;
      dx_ff   <= (qx_ff > rd_x_ff) ? (qx_ff - rd_x_ff) : (rd_x_ff - qx_ff);
      dy_ff   <= (qy_ff > rd_y_ff) ? (qy_ff - rd_y_ff) : (rd_y_ff - qy_ff);
      sqx_ff  <= dx_ff * dx_ff;
      sqy_ff  <= dy_ff * dy_ff;
   end

   assign link[0] = cand_ff;

   for (genvar k = 0; k < NUM_RANKS; k++) begin : g_cell
      fnns_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (clear_cells),
         .in_entry (link[k]),
         .held     (cell_held[k]),
         .pass     (link[k+1])
      );
   end

   always_comb begin
      in_flight = s1_v_ff || s2_v_ff || s3_v_ff;
      found     = '0;
      for (int k = 0; k < NUM_RANKS; k++) begin
         in_flight = in_flight || link[k].v || link[k+1].v;
         found     = found + FOUND_W'(cell_held[k].v);
      end
   end

   fnns_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (cell_held[rank_ff].d),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if ((state_ff == S_SQ_WAIT) && sqrt_done) begin
         root_ff[rank_ff] <= DIST_W'(sqrt_root);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         for (int k = 0; k < NUM_RANKS; k++) begin
            rsp_dist_ff[k]  <= cell_held[k].v ? root_ff[k] : DIST_EMPTY;
            rsp_index_ff[k] <= cell_held[k].v ? cell_held[k].i : '0;
         end
         rsp_found_ff <= found;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dist_first   = rsp_dist_ff[0];
   assign rsp_dist_second  = rsp_dist_ff[1];
   assign rsp_dist_third   = rsp_dist_ff[2];
   assign rsp_dist_fourth  = rsp_dist_ff[3];
   assign rsp_index_first  = rsp_index_ff[0];
   assign rsp_index_second = rsp_index_ff[1];
   assign rsp_index_third  = rsp_index_ff[2];
   assign rsp_index_fourth = rsp_index_ff[3];
   assign rsp_found_count  = rsp_found_ff;

   // The cell row always holds a filled prefix, sorted by distance.
   for (genvar k = 0; k < NUM_RANKS - 1; k++) begin : g_check
      a_prefix : assert property (@(posedge clock) disable iff (reset)
         cell_held[k+1].v |-> cell_held[k].v)
         else $error("cell row is not a filled prefix");
      a_sorted : assert property (@(posedge clock) disable iff (reset)
         cell_held[k+1].v |-> (cell_held[k].d <= cell_held[k+1].d))
         else $error("cell row is out of order");
   end

   a_sqrt_done : assert property (@(posedge clock) disable iff (reset)
      sqrt_done |-> (state_ff == S_SQ_WAIT))
      else $error("square root finished outside its wait state");

   a_out_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && rsp_valid_ff && !rsp_ready |=> (state_ff == S_OUT))
      else $error("finished query left before the response register was free");

endmodule

`default_nettype wire
